// ===== rtl/rdc_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers for the radix digit converter
// no dependencies
package rdc_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int VALUE_BITS  = 32;
   localparam int RADIX_BITS  = 6;
   localparam int DIGIT_BITS  = 6;
   localparam int CHAR_BITS   = 8;
   localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
   localparam int IDX_W       = $clog2(VALUE_WIDTH);

   localparam logic [RADIX_BITS-1:0] RADIX_MIN      = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX      = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET    = 6'd10;
   localparam logic [DIGIT_BITS-1:0] DECIMAL_DIGITS = 6'd10;
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO      = 8'h30;
   localparam logic [CHAR_BITS-1:0]  CHAR_LOWER_A   = 8'h61;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT,
      ST_ERR
   } rdc_state_type;

   function automatic logic radix_ok(input logic [RADIX_BITS-1:0] r);
      return (r >= RADIX_MIN) && (r <= RADIX_MAX);
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] d_ext;
      d_ext = {2'b00, d};
      if (d < DECIMAL_DIGITS) begin
         return CHAR_ZERO + d_ext;
      end
      return CHAR_LOWER_A + d_ext - {2'b00, DECIMAL_DIGITS};
   endfunction

endpackage

// ===== rtl/rdc_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces: request, response and register write
// depends on rdc_pkg
interface rdc_req_if;
   import rdc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface rdc_rsp_if;
   import rdc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] digit_char;
   logic                 last;
   logic                 error;
   modport source (output valid, output digit_char, output last, output error, input ready);
   modport sink   (input valid, input digit_char, input last, input error, output ready);
endinterface

interface rdc_csr_if;
   import rdc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [RADIX_BITS-1:0] radix;
   modport source (output valid, output radix, input ready);
   modport sink   (input valid, input radix, output ready);
endinterface

// ===== rtl/radix_digit_converter_unit.sv =====
`timescale 1ns / 1ps
// converts an unsigned value into its digit characters in the radix register's base
// depends on rdc_pkg, rdc_if and rdc_div
// sequence: divide by the radix until the quotient is zero, then emit the digits most significant first
// accept: a new value is taken only when idle, once the previous value's last beat is in the output register
// bad radix: one error beat, then back to idle
// reset: synchronous; radix returns to 10, control and output valid cleared
module radix_digit_converter_unit (
   input  logic      clock,
   input  logic      reset,
   rdc_req_if.sink   req,
   rdc_rsp_if.source rsp,
   rdc_csr_if.sink   csr
);
   import rdc_pkg::*;

   rdc_state_type          state_ff, state_in;
   logic [RADIX_BITS-1:0]  radix_ff;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DIGIT_BITS-1:0]  stack_ff [VALUE_WIDTH];
   logic                   push;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]   rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_err_ff, rsp_err_in;
   logic                   slot_free;
   logic                   accept;
   logic [CNT_W-1:0]       cnt_m1;
   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quo;
   logic [DIGIT_BITS-1:0]  div_rem;

   rdc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (radix_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr.valid) begin
         radix_ff <= csr.radix;
      end
   end

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp.ready;
      req.ready    = (state_ff == ST_IDLE);
      accept       = req.valid && (state_ff == ST_IDLE);
      cnt_m1       = cnt_ff - 1'b1;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      push         = 1'b0;
      div_start    = 1'b0;
      div_dividend = div_quo;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            div_dividend = VALUE_WIDTH'(req.value);
            if (accept) begin
               cnt_in = '0;
               if (radix_ok(radix_ff)) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               push   = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (div_quo == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = digit_to_char(stack_ff[cnt_m1[IDX_W-1:0]]);
               rsp_last_in  = (cnt_ff == CNT_W'(1));
               rsp_err_in   = 1'b0;
               cnt_in       = cnt_m1;
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_err_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // digit stack, least significant digit at the bottom
   always_ff @(posedge clock) begin
      if (push) begin
         stack_ff[cnt_ff[IDX_W-1:0]] <= div_rem;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.digit_char = rsp_char_ff;
   assign rsp.last       = rsp_last_ff;
   assign rsp.error      = rsp_err_ff;

   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_last_ff && rsp_char_ff == '0)
      else $error("error beat without last or with a character");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> cnt_ff == '0)
      else $error("digit stack not empty while idle");
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(VALUE_WIDTH))
      else $error("digit count beyond stack depth");
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_err_ff |->
         (rsp_char_ff >= CHAR_ZERO && rsp_char_ff <= 8'h39) ||
         (rsp_char_ff >= CHAR_LOWER_A && rsp_char_ff <= 8'h7a))
      else $error("digit beat outside character set");

endmodule

// ===== rtl/rdc_div.sv =====
`timescale 1ns / 1ps
// bit-serial restoring divider: one quotient bit per cycle by a 6-bit radix
// depends on rdc_pkg
module rdc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rdc_pkg::VALUE_WIDTH-1:0]     dividend,
   input  logic [rdc_pkg::RADIX_BITS-1:0]      radix,
   output logic                                done,
   output logic [rdc_pkg::VALUE_WIDTH-1:0]     quotient,
   output logic [rdc_pkg::DIGIT_BITS-1:0]      remainder
);
   import rdc_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [DIGIT_BITS-1:0]  rem_ff, rem_in;
   logic [DIGIT_BITS:0]    trial;
   logic [DIGIT_BITS:0]    diff;
   logic                   ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff    = trial - {1'b0, radix};
      ge      = trial >= {1'b0, radix};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VALUE_WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[VALUE_WIDTH-2:0], ge};
         rem_in = ge ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a finished run");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0 || start || $past(start) == 1'b0)
      else $error("divider count out of step");
   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < radix)
      else $error("remainder not below radix");

endmodule
